[sv/trc_pkg.sv]
// Shared constants, types and command/status structs for the tile map collision block.
`timescale 1ns / 1ps
package trc_pkg;

    // Tile store geometry; the store address is {row, col}
    localparam int C_MAX_COLS = 64;
    localparam int C_MAX_ROWS = 64;
    localparam int C_COL_W    = $clog2(C_MAX_COLS);
    localparam int C_ROW_W    = $clog2(C_MAX_ROWS);
    localparam int C_ADDR_W   = C_COL_W + C_ROW_W;
    localparam int C_DEPTH    = C_MAX_COLS * C_MAX_ROWS;

    localparam int C_WORD_W   = 32;
    localparam int C_IDX_W    = 29;
    localparam int C_TSIZE_W  = 11;
    localparam int C_CNT_W    = 7;
    localparam int C_COORD_W  = 16;
    localparam int C_LEN_W    = 15;
    localparam int C_SUM_W    = C_COORD_W + 1;
    localparam int C_DIV_W    = 16;
    localparam int C_DIVCNT_W = $clog2(C_DIV_W + 1);

    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = C_TSIZE_W;

    // Configuration register indices
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TILE_W   = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TILE_H   = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MAP_COLS = 2'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MAP_ROWS = 2'd3;

    localparam logic [C_TSIZE_W-1:0] C_TILE_SIZE_RST = 11'd32;
    localparam logic [C_CNT_W-1:0]   C_MAP_COLS_RST  = 7'd64;
    localparam logic [C_CNT_W-1:0]   C_MAP_ROWS_RST  = 7'd64;
    localparam logic [C_CNT_W-1:0]   C_MAX_COLS_V    = C_CNT_W'(C_MAX_COLS);
    localparam logic [C_CNT_W-1:0]   C_MAX_ROWS_V    = C_CNT_W'(C_MAX_ROWS);

    // Column/row reported when nothing is found (-1)
    localparam logic [C_CNT_W-1:0] C_NO_HIT_POS = '1;

    // Rectangle edge slots, divided in this order
    typedef logic [1:0] t_slot;
    localparam t_slot C_SLOT_LEFT   = 2'd0;
    localparam t_slot C_SLOT_RIGHT  = 2'd1;
    localparam t_slot C_SLOT_TOP    = 2'd2;
    localparam t_slot C_SLOT_BOTTOM = 2'd3;

    typedef struct packed {
        logic  clr_en;
        logic  tile_wr;
        logic  load;
        logic  div_start;
        logic  div_store;
        t_slot div_sel;
        logic  scan_init;
        logic  scan_en;
        logic  finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic found;
        logic scan_done;
    } t_dp_status;

endpackage

[sv/trc_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module trc_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/trc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module trc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [trc_pkg::C_DIV_W-1:0]  i_dividend,
    input  logic [trc_pkg::C_TSIZE_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [trc_pkg::C_DIV_W-1:0]  o_quotient
);
    import trc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [C_DIVCNT_W-1:0] r_cnt;
    logic [C_TSIZE_W-1:0]  r_rem;
    logic [C_TSIZE_W-1:0]  r_dvs;
    logic [C_DIV_W-1:0]    r_quo;

    logic [C_TSIZE_W+1:0]  w_diff;
    logic                  w_borrow;
    logic [C_TSIZE_W-1:0]  w_rem_next;

    // quotient bits shift in at the bottom while dividend bits leave at the top
    assign w_diff     = {1'b0, r_rem, r_quo[C_DIV_W-1]} - {2'b00, r_dvs};
    assign w_borrow   = w_diff[C_TSIZE_W+1];
    assign w_rem_next = w_borrow ? {r_rem[C_TSIZE_W-2:0], r_quo[C_DIV_W-1]}
                                 : w_diff[C_TSIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_DIVCNT_W'(C_DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - C_DIVCNT_W'(1);
                if (r_cnt == C_DIVCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[C_DIV_W-2:0], ~w_borrow};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/trc_datapath.sv]
// Datapath: config registers, edge division and clamping, tile store, scan and result.
`timescale 1ns / 1ps
module trc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  trc_pkg::t_dp_cmd                 i_cmd,
    output trc_pkg::t_dp_status              o_status,
    input  logic                             i_cfg_we,
    input  logic [trc_pkg::C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trc_pkg::C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic [trc_pkg::C_COL_W-1:0]      i_tile_col,
    input  logic [trc_pkg::C_ROW_W-1:0]      i_tile_row,
    input  logic [trc_pkg::C_WORD_W-1:0]     i_tile_word,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_x,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_y,
    input  logic [trc_pkg::C_LEN_W-1:0]      i_rect_w,
    input  logic [trc_pkg::C_LEN_W-1:0]      i_rect_h,
    output logic                             o_hit,
    output logic [trc_pkg::C_IDX_W-1:0]      o_hit_index,
    output logic signed [trc_pkg::C_CNT_W-1:0] o_hit_col,
    output logic signed [trc_pkg::C_CNT_W-1:0] o_hit_row
);
    import trc_pkg::*;

    // configuration
    logic [C_TSIZE_W-1:0] r_tile_w;
    logic [C_TSIZE_W-1:0] r_tile_h;
    logic [C_CNT_W-1:0]   r_map_cols;
    logic [C_CNT_W-1:0]   r_map_rows;
    logic [C_CNT_W-1:0]   w_cols;
    logic [C_CNT_W-1:0]   w_rows;

    // latched query
    logic [C_SUM_W-1:0]   r_x;
    logic [C_SUM_W-1:0]   r_xe;
    logic [C_SUM_W-1:0]   r_y;
    logic [C_SUM_W-1:0]   r_ye;

    // division
    logic [C_SUM_W-1:0]   w_opnd;
    logic [C_DIV_W-1:0]   w_dividend;
    logic [C_TSIZE_W-1:0] w_divisor;
    logic [C_TSIZE_W-1:0] w_tw_eff;
    logic [C_TSIZE_W-1:0] w_th_eff;
    logic                 w_div_done;
    logic [C_DIV_W-1:0]   w_quo;
    logic [C_CNT_W-1:0]   w_lim;
    logic [C_CNT_W-1:0]   w_clamped;

    logic [C_CNT_W-1:0]   r_left;
    logic [C_CNT_W-1:0]   r_right;
    logic [C_CNT_W-1:0]   r_top;
    logic [C_CNT_W-1:0]   r_bottom;

    // scan
    logic [C_COL_W-1:0]   r_col;
    logic [C_ROW_W-1:0]   r_row;
    logic [C_COL_W-1:0]   r_col_end;
    logic [C_ROW_W-1:0]   r_row_end;
    logic                 r_active;
    logic                 r_chk_valid;
    logic [C_COL_W-1:0]   r_chk_col;
    logic [C_ROW_W-1:0]   r_chk_row;
    logic [C_CNT_W-1:0]   w_cols_m1;
    logic [C_CNT_W-1:0]   w_rows_m1;
    logic                 w_found;

    // store
    logic [C_ADDR_W-1:0]  r_clr_addr;
    logic                 w_tile_we;
    logic                 w_ram_we;
    logic [C_ADDR_W-1:0]  w_ram_waddr;
    logic [C_IDX_W-1:0]   w_ram_wdata;
    logic [C_IDX_W-1:0]   w_ram_rdata;

    // results
    logic                 r_hit;
    logic [C_IDX_W-1:0]   r_hit_index;
    logic [C_CNT_W-1:0]   r_hit_col;
    logic [C_CNT_W-1:0]   r_hit_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w   <= C_TILE_SIZE_RST;
            r_tile_h   <= C_TILE_SIZE_RST;
            r_map_cols <= C_MAP_COLS_RST;
            r_map_rows <= C_MAP_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_TILE_W:   r_tile_w   <= i_cfg_data;
                C_REG_TILE_H:   r_tile_h   <= i_cfg_data;
                C_REG_MAP_COLS: r_map_cols <= i_cfg_data[C_CNT_W-1:0];
                C_REG_MAP_ROWS: r_map_rows <= i_cfg_data[C_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cols    = (r_map_cols < C_MAX_COLS_V) ? r_map_cols : C_MAX_COLS_V;
    assign w_rows    = (r_map_rows < C_MAX_ROWS_V) ? r_map_rows : C_MAX_ROWS_V;
    assign w_cols_m1 = w_cols - C_CNT_W'(1);
    assign w_rows_m1 = w_rows - C_CNT_W'(1);
    assign w_tw_eff  = (r_tile_w == '0) ? C_TSIZE_W'(1) : r_tile_w;
    assign w_th_eff  = (r_tile_h == '0) ? C_TSIZE_W'(1) : r_tile_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= C_SUM_W'(i_rect_x);
            r_y  <= C_SUM_W'(i_rect_y);
            r_xe <= C_SUM_W'(i_rect_x) + {{(C_SUM_W-C_LEN_W){1'b0}}, i_rect_w};
            r_ye <= C_SUM_W'(i_rect_y) + {{(C_SUM_W-C_LEN_W){1'b0}}, i_rect_h};
        end
    end

    always_comb begin
        case (i_cmd.div_sel) inside
            C_SLOT_LEFT:   w_opnd = r_x;
            C_SLOT_RIGHT:  w_opnd = r_xe;
            C_SLOT_TOP:    w_opnd = r_y;
            default:       w_opnd = r_ye;
        endcase
        case (i_cmd.div_sel) inside
            C_SLOT_LEFT, C_SLOT_RIGHT: begin
                w_divisor = w_tw_eff;
                w_lim     = w_cols;
            end
            default: begin
                w_divisor = w_th_eff;
                w_lim     = w_rows;
            end
        endcase
    end

    // a negative edge truncates to zero or below and clamps to zero anyway
    assign w_dividend = w_opnd[C_SUM_W-1] ? '0 : w_opnd[C_DIV_W-1:0];

    trc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_clamped = (w_quo >= {{(C_DIV_W-C_CNT_W){1'b0}}, w_lim}) ? w_lim
                                                                     : w_quo[C_CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel) inside
                C_SLOT_LEFT:  r_left   <= w_clamped;
                C_SLOT_RIGHT: r_right  <= w_clamped;
                C_SLOT_TOP:   r_top    <= w_clamped;
                default:      r_bottom <= w_clamped;
            endcase
        end
    end

    // Scan: address issued one cycle, the tile checked the next.
    // Right and bottom edges at cols/rows are trimmed to the last tile in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_chk_valid <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_active    <= (r_left < w_cols) && (r_top < w_rows);
            r_chk_valid <= 1'b0;
        end else if (i_cmd.scan_en) begin
            r_chk_valid <= r_active;
            if (r_active && (r_row == r_row_end) && (r_col == r_col_end)) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_col     <= r_left[C_COL_W-1:0];
            r_row     <= r_top[C_ROW_W-1:0];
            r_col_end <= (r_right < w_cols) ? r_right[C_COL_W-1:0] : w_cols_m1[C_COL_W-1:0];
            r_row_end <= (r_bottom < w_rows) ? r_bottom[C_ROW_W-1:0]
                                              : w_rows_m1[C_ROW_W-1:0];
        end else if (i_cmd.scan_en && r_active) begin
            r_chk_col <= r_col;
            r_chk_row <= r_row;
            if (r_row == r_row_end) begin
                r_row <= r_top[C_ROW_W-1:0];
                r_col <= r_col + C_COL_W'(1);
            end else begin
                r_row <= r_row + C_ROW_W'(1);
            end
        end
    end

    assign w_found = r_chk_valid && (w_ram_rdata != '0);

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + C_ADDR_W'(1);
        end
    end

    assign w_tile_we   = i_cmd.tile_wr && ({1'b0, i_tile_col} < w_cols)
                                       && ({1'b0, i_tile_row} < w_rows);
    assign w_ram_we    = i_cmd.clr_en || w_tile_we;
    assign w_ram_waddr = i_cmd.clr_en ? r_clr_addr : {i_tile_row, i_tile_col};
    // flip flags dropped
    assign w_ram_wdata = i_cmd.clr_en ? '0 : i_tile_word[C_IDX_W-1:0];

    trc_ram #(
        .WIDTH (C_IDX_W),
        .DEPTH (C_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr ({r_row, r_col}),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hit       <= w_found;
            r_hit_index <= w_found ? w_ram_rdata : '0;
            r_hit_col   <= w_found ? {1'b0, r_chk_col} : C_NO_HIT_POS;
            r_hit_row   <= w_found ? {1'b0, r_chk_row} : C_NO_HIT_POS;
        end
    end

    assign o_status.clr_last  = &r_clr_addr;
    assign o_status.div_done  = w_div_done;
    assign o_status.found     = w_found;
    assign o_status.scan_done = !r_active && !r_chk_valid;

    assign o_hit       = r_hit;
    assign o_hit_index = r_hit_index;
    assign o_hit_col   = r_hit_col;
    assign o_hit_row   = r_hit_row;

endmodule

[sv/trc_ctrl.sv]
// Controller: sequences store clearing, tile writes, each edge's division and the tile scan.
`timescale 1ns / 1ps
module trc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_mode,
    input  trc_pkg::t_dp_status i_status,
    output trc_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_valid
);
    import trc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR     = 6'b000001,
        S_IDLE      = 6'b000010,
        S_DIV_GO    = 6'b000100,
        S_DIV_WAIT  = 6'b001000,
        S_SCAN_INIT = 6'b010000,
        S_SCAN      = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_slot   r_sel;
    t_slot   n_sel;
    logic    r_valid;
    logic    n_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_valid       = 1'b0;
        w_cmd         = '0;
        w_cmd.div_sel = r_sel;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        w_cmd.load = 1'b1;
                        n_sel      = C_SLOT_LEFT;
                        n_state    = S_DIV_GO;
                    end else begin
                        w_cmd.tile_wr = 1'b1;
                    end
                end
            end
            S_DIV_GO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    w_cmd.div_store = 1'b1;
                    if (r_sel == C_SLOT_BOTTOM) begin
                        n_state = S_SCAN_INIT;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_SCAN_INIT: begin
                w_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                w_cmd.scan_en = 1'b1;
                if (i_status.found || i_status.scan_done) begin
                    w_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sel   <= C_SLOT_LEFT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

[sv/tilemap_rect_collision_core.sv]
// Top level of the tile map rectangle collision block.
//
// After reset the block clears its 64 x 64 tile store, one entry a cycle, and holds
// busy high until the sweep is done; configuration writes are taken throughout. A beat
// is taken when start is high and busy is low. A tile write (mode 0) is written to
// the store in the cycle it is taken and busy stays low. A query (mode 1) runs four
// divisions of the rectangle edges by the tile size on one shared divider, then
// reads the tile store one tile per cycle over the clamped rectangle, column by
// column, stopping at the first nonzero tile. The store read port sets the scan rate.
// The result beat is shown for a single cycle on o_valid and cannot be held off.
`timescale 1ns / 1ps
module tilemap_rect_collision_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [trc_pkg::C_CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trc_pkg::C_CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_mode,
    input  logic [trc_pkg::C_COL_W-1:0]          i_tile_col,
    input  logic [trc_pkg::C_ROW_W-1:0]          i_tile_row,
    input  logic [trc_pkg::C_WORD_W-1:0]         i_tile_word,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_x,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_y,
    input  logic [trc_pkg::C_LEN_W-1:0]          i_rect_w,
    input  logic [trc_pkg::C_LEN_W-1:0]          i_rect_h,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic [trc_pkg::C_IDX_W-1:0]          o_hit_index,
    output logic signed [trc_pkg::C_CNT_W-1:0]   o_hit_col,
    output logic signed [trc_pkg::C_CNT_W-1:0]   o_hit_row
);
    import trc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    trc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    trc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_tile_word (i_tile_word),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .o_hit       (o_hit),
        .o_hit_index (o_hit_index),
        .o_hit_col   (o_hit_col),
        .o_hit_row   (o_hit_row)
    );

endmodule

[sv/trc_checker.sv]
// Port-level checker for the tile map collision block, bound to the top level.
`timescale 1ns / 1ps
module trc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_mode,
    input logic                               o_valid,
    input logic                               o_hit,
    input logic [trc_pkg::C_IDX_W-1:0]        o_hit_index,
    input logic [trc_pkg::C_CNT_W-1:0]        o_hit_col,
    input logic [trc_pkg::C_CNT_W-1:0]        o_hit_row
);
    import trc_pkg::*;

    // a query beat is always followed by busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode) |=> busy)
        else $error("query beat not followed by busy");

    // a tile write never yields a result beat
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_mode) |=> !o_valid)
        else $error("result beat after a tile write");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat lasted more than one cycle");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |->
            (o_hit_index == '0) && (o_hit_col == C_NO_HIT_POS) && (o_hit_row == C_NO_HIT_POS))
        else $error("miss beat with stray fields");

    a_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |->
            (o_hit_index != '0) && !o_hit_col[C_CNT_W-1] && !o_hit_row[C_CNT_W-1])
        else $error("hit beat with zero index or negative position");

endmodule

bind tilemap_rect_collision_core trc_checker u_trc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_mode      (i_mode),
    .o_valid     (o_valid),
    .o_hit       (o_hit),
    .o_hit_index (o_hit_index),
    .o_hit_col   (o_hit_col),
    .o_hit_row   (o_hit_row)
);

[tb/tilemap_tb_pkg.sv]
// Mode codes and the result record used by the collision testbench files.
`timescale 1ns / 1ps
package tilemap_tb_pkg;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    typedef struct packed {
        logic                                hit;
        logic [trc_pkg::C_IDX_W-1:0]         index;
        logic signed [trc_pkg::C_CNT_W-1:0]  col;
        logic signed [trc_pkg::C_CNT_W-1:0]  row;
    } t_hit_rec;

endpackage

[tb/collision_predict_check.sv]
// Tile map mirror and collision predictor; checks every result beat of the core.
`timescale 1ns / 1ps
module collision_predict_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [trc_pkg::C_CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trc_pkg::C_CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_mode,
    input  logic [trc_pkg::C_COL_W-1:0]          i_tile_col,
    input  logic [trc_pkg::C_ROW_W-1:0]          i_tile_row,
    input  logic [trc_pkg::C_WORD_W-1:0]         i_tile_word,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_x,
    input  logic signed [trc_pkg::C_COORD_W-1:0] i_rect_y,
    input  logic [trc_pkg::C_LEN_W-1:0]          i_rect_w,
    input  logic [trc_pkg::C_LEN_W-1:0]          i_rect_h,
    input  logic                                 o_valid,
    input  logic                                 o_hit,
    input  logic [trc_pkg::C_IDX_W-1:0]          o_hit_index,
    input  logic signed [trc_pkg::C_CNT_W-1:0]   o_hit_col,
    input  logic signed [trc_pkg::C_CNT_W-1:0]   o_hit_row,
    output int                                   o_err_cnt,
    output int                                   o_pending,
    output int                                   o_hits,
    output int                                   o_misses
);
    import trc_pkg::*;
    import tilemap_tb_pkg::*;

    logic [C_IDX_W-1:0]   tile_map [0:C_DEPTH-1];
    logic [C_TSIZE_W-1:0] tw_reg;
    logic [C_TSIZE_W-1:0] th_reg;
    logic [C_CNT_W-1:0]   cols_reg;
    logic [C_CNT_W-1:0]   rows_reg;
    t_hit_rec             expected_hits [$];
    int                   err_total  = 0;
    int                   hit_total  = 0;
    int                   miss_total = 0;

    assign o_err_cnt = err_total;
    assign o_hits    = hit_total;
    assign o_misses  = miss_total;

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Column-major scan of the clamped rectangle, first nonzero entry wins
    function automatic t_hit_rec first_solid_tile(input logic signed [C_COORD_W-1:0] x,
                                                  input logic signed [C_COORD_W-1:0] y,
                                                  input logic [C_LEN_W-1:0] w,
                                                  input logic [C_LEN_W-1:0] h);
        int       ncol;
        int       nrow;
        int       tw;
        int       th;
        int       xs;
        int       ys;
        int       lo_c;
        int       hi_c;
        int       lo_r;
        int       hi_r;
        bit       found;
        t_hit_rec r;
        ncol = (int'(cols_reg) < C_MAX_COLS) ? int'(cols_reg) : C_MAX_COLS;
        nrow = (int'(rows_reg) < C_MAX_ROWS) ? int'(rows_reg) : C_MAX_ROWS;
        tw   = (tw_reg == '0) ? 1 : int'(tw_reg);
        th   = (th_reg == '0) ? 1 : int'(th_reg);
        xs   = x;
        ys   = y;
        lo_c = clip(xs / tw, ncol);
        hi_c = clip((xs + int'(w)) / tw, ncol);
        lo_r = clip(ys / th, nrow);
        hi_r = clip((ys + int'(h)) / th, nrow);
        r.hit   = 1'b0;
        r.index = '0;
        r.col   = C_NO_HIT_POS;
        r.row   = C_NO_HIT_POS;
        found   = 1'b0;
        for (int i = lo_c; i <= hi_c && !found; i++) begin
            for (int j = lo_r; j <= hi_r && !found; j++) begin
                if (i < ncol && j < nrow && tile_map[j * C_MAX_COLS + i] != '0) begin
                    found   = 1'b1;
                    r.hit   = 1'b1;
                    r.index = tile_map[j * C_MAX_COLS + i];
                    r.col   = C_CNT_W'(i);
                    r.row   = C_CNT_W'(j);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hit_rec want;
        int       ncol;
        int       nrow;
        if (!i_rst_n) begin
            for (int k = 0; k < C_DEPTH; k++)
                tile_map[k] = '0;
            tw_reg   = C_TILE_SIZE_RST;
            th_reg   = C_TILE_SIZE_RST;
            cols_reg = C_MAP_COLS_RST;
            rows_reg = C_MAP_ROWS_RST;
            expected_hits.delete();
        end else begin
            if (start && !busy) begin
                if (i_mode == MODE_QUERY) begin
                    expected_hits.insert(expected_hits.size(),
                                         first_solid_tile(i_rect_x, i_rect_y,
                                                          i_rect_w, i_rect_h));
                end else begin
                    ncol = (int'(cols_reg) < C_MAX_COLS) ? int'(cols_reg) : C_MAX_COLS;
                    nrow = (int'(rows_reg) < C_MAX_ROWS) ? int'(rows_reg) : C_MAX_ROWS;
                    // flip flags fall away with the top three bits
                    if (int'(i_tile_col) < ncol && int'(i_tile_row) < nrow)
                        tile_map[int'(i_tile_row) * C_MAX_COLS + int'(i_tile_col)] =
                            i_tile_word[C_IDX_W-1:0];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    C_REG_TILE_W:   tw_reg   = i_cfg_data;
                    C_REG_TILE_H:   th_reg   = i_cfg_data;
                    C_REG_MAP_COLS: cols_reg = i_cfg_data[C_CNT_W-1:0];
                    C_REG_MAP_ROWS: rows_reg = i_cfg_data[C_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (expected_hits.size() == 0) begin
                    $error("result beat with no query outstanding");
                    err_total++;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit)
                        hit_total++;
                    else
                        miss_total++;
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                        err_total++;
                    end
                    if (o_hit_index !== want.index) begin
                        $error("hit_index: expected 0x%0h, actual 0x%0h",
                               want.index, o_hit_index);
                        err_total++;
                    end
                    if (o_hit_col !== want.col) begin
                        $error("hit_col: expected %0d, actual %0d", want.col, o_hit_col);
                        err_total++;
                    end
                    if (o_hit_row !== want.row) begin
                        $error("hit_row: expected %0d, actual %0d", want.row, o_hit_row);
                        err_total++;
                    end
                end
            end
        end
        o_pending <= expected_hits.size();
    end

endmodule

[tb/tb_tilemap_rect_collision_core.sv]
// Stimulus and verdict for the tile map rectangle collision core.
`timescale 1ns / 1ps
module tb_tilemap_rect_collision_core;
    import trc_pkg::*;
    import tilemap_tb_pkg::*;

    localparam int C_CYCLE_LIMIT = 3_000_000;
    localparam int C_SETTLE      = 20;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    logic                       i_cfg_we    = 1'b0;
    logic [C_CFG_IDX_W-1:0]     i_cfg_idx   = '0;
    logic [C_CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                       i_mode      = 1'b0;
    logic [C_COL_W-1:0]         i_tile_col  = '0;
    logic [C_ROW_W-1:0]         i_tile_row  = '0;
    logic [C_WORD_W-1:0]        i_tile_word = '0;
    logic signed [C_COORD_W-1:0] i_rect_x   = '0;
    logic signed [C_COORD_W-1:0] i_rect_y   = '0;
    logic [C_LEN_W-1:0]         i_rect_w    = '0;
    logic [C_LEN_W-1:0]         i_rect_h    = '0;
    logic                       o_valid;
    logic                       o_hit;
    logic [C_IDX_W-1:0]         o_hit_index;
    logic signed [C_CNT_W-1:0]  o_hit_col;
    logic signed [C_CNT_W-1:0]  o_hit_row;

    int err_cnt;
    int pending;
    int n_hits;
    int n_misses;

    // shadow of what was last written to the registers
    int reg_tw     = 32;
    int reg_th     = 32;
    int reg_cols   = 64;
    int reg_rows   = 64;
    int idle_pct   = 0;
    int n_writes   = 0;
    int n_queries  = 0;
    int n_settings = 1;
    int cycles     = 0;

    always #5 i_clk = ~i_clk;

    tilemap_rect_collision_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_tile_word (i_tile_word),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_hit_index (o_hit_index),
        .o_hit_col   (o_hit_col),
        .o_hit_row   (o_hit_row)
    );

    collision_predict_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_tile_word (i_tile_word),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_hit_index (o_hit_index),
        .o_hit_col   (o_hit_col),
        .o_hit_row   (o_hit_row),
        .o_err_cnt   (err_cnt),
        .o_pending   (pending),
        .o_hits      (n_hits),
        .o_misses    (n_misses)
    );

    function automatic int in_use(input int v);
        return (v < C_MAX_COLS) ? v : C_MAX_COLS;
    endfunction

    task automatic send_beat(input t_mode m, input logic [C_COL_W-1:0] col,
                             input logic [C_ROW_W-1:0] row, input logic [C_WORD_W-1:0] word,
                             input logic [C_COORD_W-1:0] x, input logic [C_COORD_W-1:0] y,
                             input logic [C_LEN_W-1:0] w, input logic [C_LEN_W-1:0] h);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            // half the gaps start only once the core has gone idle
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_mode      <= m;
        i_tile_col  <= col;
        i_tile_row  <= row;
        i_tile_word <= word;
        i_rect_x    <= x;
        i_rect_y    <= y;
        i_rect_w    <= w;
        i_rect_h    <= h;
        do @(posedge i_clk); while (busy);
        if (m == MODE_QUERY)
            n_queries++;
        else
            n_writes++;
    endtask

    task automatic put_tile(input int col, input int row, input logic [C_WORD_W-1:0] word);
        send_beat(MODE_WRITE, C_COL_W'(col), C_ROW_W'(row), word, C_COORD_W'($urandom),
                  C_COORD_W'($urandom), C_LEN_W'($urandom), C_LEN_W'($urandom));
    endtask

    task automatic query(input int x, input int y, input int w, input int h);
        send_beat(MODE_QUERY, C_COL_W'($urandom), C_ROW_W'($urandom), $urandom,
                  C_COORD_W'(x), C_COORD_W'(y), C_LEN_W'(w), C_LEN_W'(h));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (C_SETTLE) @(posedge i_clk);
    endtask

    task automatic load_regs(input int tw, input int th, input int cols, input int rows);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= C_REG_TILE_W;
        i_cfg_data <= C_CFG_DATA_W'(tw);
        @(posedge i_clk);
        i_cfg_idx  <= C_REG_TILE_H;
        i_cfg_data <= C_CFG_DATA_W'(th);
        @(posedge i_clk);
        i_cfg_idx  <= C_REG_MAP_COLS;
        i_cfg_data <= C_CFG_DATA_W'(cols);
        @(posedge i_clk);
        i_cfg_idx  <= C_REG_MAP_ROWS;
        i_cfg_data <= C_CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_tw   = tw;
        reg_th   = th;
        reg_cols = cols;
        reg_rows = rows;
        n_settings++;
    endtask

    task automatic rand_write(output bit landed);
        int                  ncol;
        int                  nrow;
        int                  col;
        int                  row;
        logic [C_WORD_W-1:0] word;
        ncol = in_use(reg_cols);
        nrow = in_use(reg_rows);
        if (ncol > 0 && nrow > 0 && $urandom_range(0, 99) < 85) begin
            col = $urandom_range(0, ncol - 1);
            row = $urandom_range(0, nrow - 1);
        end else begin
            col = $urandom_range(0, C_MAX_COLS - 1);
            row = $urandom_range(0, C_MAX_ROWS - 1);
        end
        case ($urandom_range(0, 9))
            0, 1:    word = '0;
            2:       word = {3'($urandom), 29'd0};
            default: word = $urandom;
        endcase
        landed = (col < ncol && row < nrow);
        put_tile(col, row, word);
    endtask

    task automatic rand_query();
        int tw;
        int th;
        int x;
        int y;
        int w;
        int h;
        tw = (reg_tw == 0) ? 1 : reg_tw;
        th = (reg_th == 0) ? 1 : reg_th;
        if ($urandom_range(0, 9) < 7) begin
            // rectangles around the map, a few tiles across
            x = int'($urandom_range(0, (in_use(reg_cols) + 2) * tw)) - tw;
            y = int'($urandom_range(0, (in_use(reg_rows) + 2) * th)) - th;
            w = $urandom_range(0, (3 * tw < 32767) ? 3 * tw : 32767);
            h = $urandom_range(0, (3 * th < 32767) ? 3 * th : 32767);
        end else begin
            x = $urandom;
            y = $urandom;
            w = $urandom;
            h = $urandom;
        end
        query(x, y, w, h);
    endtask

    task automatic run_phase(input int tw, input int th, input int cols, input int rows,
                             input int target, input int idle, input bit mid_pause);
        int done;
        bit landed;
        bit paused;
        done   = 0;
        paused = 1'b0;
        drain_results();
        load_regs(tw, th, cols, rows);
        idle_pct = idle;
        while (done < target) begin
            if (mid_pause && !paused && done >= target / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 55) begin
                rand_write(landed);
                if (landed)
                    done++;
            end else begin
                rand_query();
                done++;
            end
        end
    endtask

    initial begin
        while (cycles < C_CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_tilemap_rect_collision_core NOT OK");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on the reset geometry: 32 x 32 pixel tiles, 64 x 64 map
        query(0, 0, 32767, 32767);              // empty map, full scan
        put_tile(0, 0, 32'hFFFF_FFFF);
        query(-32768, -32768, 0, 0);            // wholly above-left, clamps onto (0,0)
        put_tile(0, 0, 32'h0000_0000);
        put_tile(63, 63, 32'hE000_0000);        // flags only, index zero
        query(2016, 2016, 31, 31);
        put_tile(63, 63, 32'h2000_0001);
        query(2016, 2016, 31, 31);
        put_tile(5, 7, 32'h8000_0005);
        put_tile(5, 2, 32'h4000_0009);
        put_tile(4, 40, 32'h0000_0003);
        query(128, 0, 64, 2047);                // earlier column beats higher row
        query(160, -33, 31, 300);
        query(-31, -1, 0, 0);                   // truncation towards zero
        query(32767, 32767, 32767, 32767);      // wholly past the map, nothing scanned
        query(-32768, -32768, 32767, 32767);
        put_tile(63, 0, 32'h1FFF_FFFF);
        query(2047, -5, 0, 0);
        query(0, 224, 32767, 0);

        run_phase(1, 1, 64, 64, 18, 30, 1'b0);
        run_phase(1024, 1024, 1, 1, 12, 40, 1'b0);
        run_phase(0, 2047, 127, 100, 15, 20, 1'b0);    // zero width, oversize map
        run_phase(7, 13, 0, 17, 5, 30, 1'b0);          // no columns in use
        run_phase($urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(1, 64), $urandom_range(1, 64), 18, 0, 1'b1);
        run_phase(37, 5, 64, 0, 4, 30, 1'b0);          // no rows in use
        run_phase(16, 8, 64, 64, 28, 0, 1'b0);         // closing stretch, no gaps
        drain_results();

        $display("covered %0d tile writes and %0d queries (%0d hits, %0d misses)",
                 n_writes, n_queries, n_hits, n_misses);
        $display("over %0d register settings incl. zero, oversize and extreme geometries",
                 n_settings);
        if (err_cnt == 0 && pending == 0)
            $display("tb_tilemap_rect_collision_core OK");
        else
            $display("tb_tilemap_rect_collision_core NOT OK");
        $finish;
    end

endmodule
